@@ hw/rtl/key_press_event_classifier_assert.svh @@
// assertion macros for the key press event classifier
`ifndef KEY_PRESS_EVENT_CLASSIFIER_ASSERT_SVH
`define KEY_PRESS_EVENT_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// checked while out of reset
`define KPEC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kpec assertion failed");

// checked on every edge, reset included
`define KPEC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kpec assertion failed");

`else

`define KPEC_ASSERT(lbl, clk, rst_n, prop)
`define KPEC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hw/rtl/kpec_pkg.sv @@
// shared types and constants for the key press event classifier
package kpec_pkg;

  localparam int NUM_KEYS  = 3;
  localparam int SLOT_N    = NUM_KEYS + 1;
  localparam int CNT_W     = 12;
  localparam int KEY_W     = 2;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT    = 3'd4;

  // register reset values
  localparam logic [CNT_W-1:0] RST_RELEASE_TICKS = 12'd3;
  localparam logic [CNT_W-1:0] RST_PRESS_TICKS   = 12'd6;
  localparam logic [CNT_W-1:0] RST_LONG_TICKS    = 12'd150;
  localparam logic [CNT_W-1:0] RST_HOLD_TICKS    = 12'd180;
  localparam logic [CNT_W-1:0] RST_IDLE_LIMIT    = 12'd8;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESS    = 3'd0,
    EV_LONG     = 3'd1,
    EV_HOLD     = 3'd2,
    EV_SHORT_UP = 3'd3,
    EV_LONG_UP  = 3'd4,
    EV_IDLE     = 3'd5
  } ev_kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] release_ticks;
    logic [CNT_W-1:0] press_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] hold_ticks;
    logic [CNT_W-1:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    ev_kind_t kind;
  } key_evt_t;

endpackage

@@ hw/rtl/kpec_key.sv @@
// debounce and press classification state of one key
module kpec_key (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              level,
  input  kpec_pkg::cfg_t    cfg,
  output kpec_pkg::key_evt_t evt
);
  import kpec_pkg::*;

  logic             held_r, held_nxt;
  logic [CNT_W-1:0] press_cnt_r, press_cnt_nxt;
  logic [CNT_W-1:0] rel_cnt_r, rel_cnt_nxt;
  logic [CNT_W-1:0] press_inc;

  // saturating press count
  assign press_inc = (press_cnt_r != CNT_MAX) ? press_cnt_r + 1'b1 : press_cnt_r;

  // tick evaluation
  always_comb begin
    held_nxt      = held_r;
    press_cnt_nxt = press_cnt_r;
    rel_cnt_nxt   = rel_cnt_r;
    evt.valid     = 1'b0;
    evt.kind      = EV_PRESS;
    if (!level || !held_r) begin
      if (rel_cnt_r < cfg.release_ticks) begin
        rel_cnt_nxt = rel_cnt_r + 1'b1;
      end else begin
        if (held_r) begin
          if (press_cnt_r >= cfg.long_ticks) begin
            evt.valid = 1'b1;
            evt.kind  = EV_LONG_UP;
          end else if (press_cnt_r >= cfg.press_ticks) begin
            evt.valid = 1'b1;
            evt.kind  = EV_SHORT_UP;
          end
        end
        held_nxt      = level;
        press_cnt_nxt = '0;
      end
    end else begin
      press_cnt_nxt = press_inc;
      if (press_inc == cfg.press_ticks) begin
        rel_cnt_nxt = '0;
        evt.valid   = 1'b1;
        evt.kind    = EV_PRESS;
      end else if (press_inc == cfg.long_ticks) begin
        evt.valid = 1'b1;
        evt.kind  = EV_LONG;
      end else if (press_inc == cfg.hold_ticks) begin
        evt.valid     = 1'b1;
        evt.kind      = EV_HOLD;
        press_cnt_nxt = cfg.long_ticks;
      end
    end
  end

  // key state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      press_cnt_r <= '0;
      rel_cnt_r   <= '0;
    end else if (step) begin
      held_r      <= held_nxt;
      press_cnt_r <= press_cnt_nxt;
      rel_cnt_r   <= rel_cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/key_press_event_classifier.sv @@
// top level of the key press event classifier
//
// channel   direction  handshake              contents
// in_       slave      in_tvalid/in_tready    one scan tick of key levels
// out_      master     out_tvalid/out_tready  one event, tlast on the last of its tick
// cfg_      write      cfg_wr_en              register index and 12-bit value
//
// a tick is latched in the input register and evaluated into an event queue
// of up to four words, which then drains one word a cycle through the output
// register whenever a low out_tready does not stall it.
// a new tick is taken while the previous one's last word still waits.
// reset is synchronous and clears key state, counters, configuration and valid flags; data registers are not reset.
// stalls on out_tready hold the output word and back up into in_tready.
module key_press_event_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  // key_levels [2:0], zero fill above
  input  logic [kpec_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // key_index [1:0], event_kind [4:2], zero fill above
  output logic [kpec_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [kpec_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [kpec_pkg::CNT_W-1:0]          cfg_wdata
);
  import kpec_pkg::*;

  `include "key_press_event_classifier_assert.svh"

  cfg_t                 cfg_r;
  logic                 s1_valid_r;
  logic [NUM_KEYS-1:0]  s1_levels_r;
  logic [SLOT_N-1:0]    pend_r;
  ev_kind_t             kind_r [NUM_KEYS];
  logic [CNT_W-1:0]     idle_cnt_r;
  logic                 out_valid_r;
  logic [KEY_W-1:0]     out_key_r;
  ev_kind_t             out_kind_r;
  logic                 out_last_r;

  key_evt_t             key_evt [NUM_KEYS];
  logic                 buf_empty;
  logic                 s1_go;
  logic                 any_down;
  logic [CNT_W:0]       idle_inc;
  logic                 idle_fire;
  logic                 pop;
  logic [SLOT_N-1:0]    sel;
  logic [SLOT_N-1:0]    pend_left;
  logic [KEY_W-1:0]     sel_key;
  ev_kind_t             sel_kind;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_ticks <= RST_RELEASE_TICKS;
      cfg_r.press_ticks   <= RST_PRESS_TICKS;
      cfg_r.long_ticks    <= RST_LONG_TICKS;
      cfg_r.hold_ticks    <= RST_HOLD_TICKS;
      cfg_r.idle_limit    <= RST_IDLE_LIMIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_RELEASE_TICKS: cfg_r.release_ticks <= cfg_wdata;
        REG_PRESS_TICKS:   cfg_r.press_ticks   <= cfg_wdata;
        REG_LONG_TICKS:    cfg_r.long_ticks    <= cfg_wdata;
        REG_HOLD_TICKS:    cfg_r.hold_ticks    <= cfg_wdata;
        REG_IDLE_LIMIT:    cfg_r.idle_limit    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register, emptied when the event queue can take the tick
  assign buf_empty = (pend_r == '0);
  assign s1_go     = s1_valid_r && buf_empty;
  assign in_tready = !s1_valid_r || buf_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_levels_r <= in_tdata[NUM_KEYS-1:0];
    end
  end

  // per-key state
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kpec_key u_key (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (s1_go),
      .level (s1_levels_r[k]),
      .cfg   (cfg_r),
      .evt   (key_evt[k])
    );
  end

  // idle counter, compared one bit wider so a limit at the top still fires
  assign any_down  = |s1_levels_r;
  assign idle_inc  = {1'b0, idle_cnt_r} + 1'b1;
  assign idle_fire = !any_down && (idle_inc > {1'b0, cfg_r.idle_limit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_cnt_r <= '0;
    end else if (s1_go) begin
      if (any_down || idle_fire) begin
        idle_cnt_r <= '0;
      end else begin
        idle_cnt_r <= idle_inc[CNT_W-1:0];
      end
    end
  end

  // lowest pending slot goes out first, idle slot sits on top
  assign sel       = pend_r & (~pend_r + 1'b1);
  assign pend_left = pend_r & ~sel;
  assign pop       = (!out_valid_r || out_tready) && !buf_empty;

  always_comb begin
    sel_key  = '0;
    sel_kind = EV_IDLE;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (sel[i]) begin
        sel_key  = KEY_W'(i);
        sel_kind = kind_r[i];
      end
    end
  end

  // event queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (s1_go) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        pend_r[i] <= key_evt[i].valid;
      end
      pend_r[NUM_KEYS] <= idle_fire;
    end else if (pop) begin
      pend_r <= pend_left;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        kind_r[i] <= key_evt[i].kind;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_key_r  <= sel_key;
      out_kind_r <= sel_kind;
      out_last_r <= (pend_left == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - KEY_W - KIND_W){1'b0}}, out_kind_r, out_key_r};

  // a word that is not last leaves the rest of its tick queued
  `KPEC_ASSERT(a_rest_queued, clk, rst_n, (out_valid_r && !out_last_r) |-> (pend_r != '0))
  // the idle event always closes its tick and names key zero
  `KPEC_ASSERT(a_idle_last, clk, rst_n, (out_valid_r && out_kind_r == EV_IDLE) |-> (out_last_r && out_key_r == '0))
  // reset empties the output and the queue
  `KPEC_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> (!out_valid_r && pend_r == '0))

endmodule

@@ test/key_press_event_classifier_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the key press event classifier, with its own event predictor

module testbench;
  import kpec_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef enum {MODE_STEADY, MODE_TX_IDLE, MODE_RX_STALL, MODE_BOTH} stall_mode_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    ev_kind_t         kind;
    logic             last;
  } key_event_t;

  // directed tick: typed rows carry their events, the rest go to the predictor
  typedef struct packed {
    logic [2:0] levels;
    logic       typed;
    logic [2:0] n_ev;
    ev_kind_t   kind;
  } tick_row_t;

  // reset settings: release 3, press 6, long 150, hold 180, idle 8
  localparam tick_row_t DIR_ROWS [0:24] = '{
    '{3'b000, 1'b1, 3'd0, EV_IDLE},
    '{3'b000, 1'b1, 3'd0, EV_IDLE},
    '{3'b000, 1'b1, 3'd0, EV_IDLE},
    '{3'b000, 1'b1, 3'd0, EV_IDLE},
    '{3'b000, 1'b1, 3'd0, EV_IDLE},
    '{3'b000, 1'b1, 3'd0, EV_IDLE},
    '{3'b000, 1'b1, 3'd0, EV_IDLE},
    '{3'b000, 1'b1, 3'd0, EV_IDLE},
    '{3'b000, 1'b1, 3'd1, EV_IDLE},
    '{3'b111, 1'b0, 3'd0, EV_PRESS},
    '{3'b111, 1'b0, 3'd0, EV_PRESS},
    '{3'b111, 1'b0, 3'd0, EV_PRESS},
    '{3'b111, 1'b0, 3'd0, EV_PRESS},
    '{3'b111, 1'b0, 3'd0, EV_PRESS},
    '{3'b111, 1'b0, 3'd0, EV_PRESS},
    '{3'b111, 1'b1, 3'd3, EV_PRESS},
    '{3'b000, 1'b0, 3'd0, EV_PRESS},
    '{3'b000, 1'b0, 3'd0, EV_PRESS},
    '{3'b000, 1'b0, 3'd0, EV_PRESS},
    '{3'b000, 1'b1, 3'd3, EV_SHORT_UP},
    '{3'b000, 1'b0, 3'd0, EV_PRESS},
    '{3'b000, 1'b0, 3'd0, EV_PRESS},
    '{3'b000, 1'b0, 3'd0, EV_PRESS},
    '{3'b000, 1'b0, 3'd0, EV_PRESS},
    '{3'b000, 1'b1, 3'd1, EV_IDLE}
  };

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CNT_W-1:0]      cfg_wdata;

  stall_mode_t stall_mode = MODE_STEADY;
  int unsigned cycle_count = 0;
  int unsigned n_errors = 0;
  int unsigned events_queued = 0;
  int unsigned mode_tick = 0;

  // predictor state and its copy of the registers
  cfg_t             cls_cfg;
  logic             key_held [NUM_KEYS];
  logic [CNT_W-1:0] press_cnt [NUM_KEYS];
  logic [CNT_W-1:0] release_cnt [NUM_KEYS];
  logic [CNT_W-1:0] quiet_cnt;
  key_event_t       tick_events [$];
  key_event_t       pending_events [$];

  // random key activity: current level and ticks left in the run
  logic             run_down [NUM_KEYS];
  int unsigned      run_left [NUM_KEYS];

  key_press_event_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    case (stall_mode)
      MODE_RX_STALL: out_tready <= ($urandom_range(99) >= 54);
      MODE_BOTH:     out_tready <= ($urandom_range(99) >= 34);
      default:       out_tready <= 1'b1;
    endcase
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycle_count, got, want);
    n_errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected word, tdata", out_tdata, 0);
      end else begin
        want = pending_events.pop_front();
        if (out_tdata[1:0] !== want.key)
          report_mismatch("key_index", out_tdata[1:0], want.key);
        if (out_tdata[4:2] !== want.kind)
          report_mismatch("event_kind", out_tdata[4:2], want.kind);
        if (out_tlast !== want.last)
          report_mismatch("tlast", out_tlast, want.last);
      end
    end
  end

  function automatic void add_event(input int k, input ev_kind_t kind);
    key_event_t ev;
    ev.key  = k[KEY_W-1:0];
    ev.kind = kind;
    ev.last = 1'b0;
    tick_events.push_back(ev);
  endfunction

  // one scan tick through the debouncer, events left in tick_events
  function automatic void predict_tick(input logic [2:0] lv);
    logic [CNT_W:0] quiet_next;
    tick_events.delete();
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!lv[k] || !key_held[k]) begin
        if (release_cnt[k] < cls_cfg.release_ticks) begin
          release_cnt[k] = release_cnt[k] + 1'b1;
        end else begin
          if (key_held[k]) begin
            if (press_cnt[k] >= cls_cfg.long_ticks) add_event(k, EV_LONG_UP);
            else if (press_cnt[k] >= cls_cfg.press_ticks) add_event(k, EV_SHORT_UP);
          end
          key_held[k]  = lv[k];
          press_cnt[k] = '0;
        end
      end else begin
        // counter sticks at the top
        if (press_cnt[k] != CNT_MAX) press_cnt[k] = press_cnt[k] + 1'b1;
        if (press_cnt[k] == cls_cfg.press_ticks) begin
          release_cnt[k] = '0;
          add_event(k, EV_PRESS);
        end else if (press_cnt[k] == cls_cfg.long_ticks) begin
          add_event(k, EV_LONG);
        end else if (press_cnt[k] == cls_cfg.hold_ticks) begin
          add_event(k, EV_HOLD);
          press_cnt[k] = cls_cfg.long_ticks;
        end
      end
    end
    // idle count compared one bit wider so a limit at the top still fires
    if (lv == 3'b000) begin
      quiet_next = {1'b0, quiet_cnt} + 1'b1;
      if (quiet_next > {1'b0, cls_cfg.idle_limit}) begin
        quiet_cnt = '0;
        add_event(0, EV_IDLE);
      end else begin
        quiet_cnt = quiet_next[CNT_W-1:0];
      end
    end else begin
      quiet_cnt = '0;
    end
    if (tick_events.size() > 0) tick_events[tick_events.size()-1].last = 1'b1;
  endfunction

  // next random tick: press and release runs with bounce and noise
  function automatic logic [2:0] next_random_levels();
    logic [2:0] lv;
    int unsigned span;
    if ($urandom_range(99) < 6) begin
      // quiet stretch so that idle events come
      span = int'(cls_cfg.release_ticks) + int'(cls_cfg.idle_limit) + 3;
      if (span > 30) span = 30;
      for (int k = 0; k < NUM_KEYS; k++) begin
        run_down[k] = 1'b0;
        run_left[k] = span;
      end
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (run_left[k] == 0) begin
        run_down[k] = !run_down[k];
        if (run_down[k]) begin
          span = int'(cls_cfg.hold_ticks) + 4;
          if (span > 40) span = 40;
          if ($urandom_range(3) == 0) span = 3;
        end else begin
          span = int'(cls_cfg.release_ticks) + 3;
          if (span > 12) span = 12;
        end
        run_left[k] = $urandom_range(span, 1);
      end
      run_left[k]--;
      lv[k] = run_down[k];
    end
    if ($urandom_range(99) < 8) lv = 3'($urandom_range(7));
    return lv;
  endfunction

  // hand one tick to the block; a typed row replaces the predicted events
  task automatic send_tick(input logic [2:0] lv, input logic typed, input int n_ev,
                           input ev_kind_t kind);
    key_event_t ev;
    int unsigned gap_pct;
    gap_pct = (stall_mode == MODE_TX_IDLE) ? 54 : (stall_mode == MODE_BOTH) ? 34 : 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = IN_DATA_W'(lv);
    do @(posedge clk); while (!in_tready);
    predict_tick(lv);
    if (typed) begin
      for (int i = 0; i < n_ev; i++) begin
        ev.key  = i[KEY_W-1:0];
        ev.kind = kind;
        ev.last = (i == n_ev - 1);
        pending_events.push_back(ev);
      end
      events_queued += n_ev;
    end else begin
      foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
      events_queued += tick_events.size();
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // hold the sender until every expected word is out, then let the pipe empty
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_RELEASE_TICKS: cls_cfg.release_ticks = val;
      REG_PRESS_TICKS:   cls_cfg.press_ticks   = val;
      REG_LONG_TICKS:    cls_cfg.long_ticks    = val;
      REG_HOLD_TICKS:    cls_cfg.hold_ticks    = val;
      REG_IDLE_LIMIT:    cls_cfg.idle_limit    = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input int rel, input int prs, input int lng, input int hld,
                                input int idl);
    wait_drained();
    write_reg(REG_RELEASE_TICKS, CNT_W'(rel));
    write_reg(REG_PRESS_TICKS,   CNT_W'(prs));
    write_reg(REG_LONG_TICKS,    CNT_W'(lng));
    write_reg(REG_HOLD_TICKS,    CNT_W'(hld));
    write_reg(REG_IDLE_LIMIT,    CNT_W'(idl));
  endtask

  // random ticks, stall mode rotating every dozen ticks
  task automatic send_random(input int unsigned n_min, input int unsigned events_min);
    int unsigned n_sent;
    int unsigned events_start;
    n_sent       = 0;
    events_start = events_queued;
    while ((n_sent < n_min || events_queued - events_start < events_min)
           && n_sent < n_min + 1500) begin
      stall_mode = stall_mode_t'((mode_tick / 12) % 4);
      mode_tick++;
      send_tick(next_random_levels(), 1'b0, 0, EV_PRESS);
      n_sent++;
    end
    stall_mode = MODE_STEADY;
  endtask

  initial begin
    int unsigned lng;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    cls_cfg = '{RST_RELEASE_TICKS, RST_PRESS_TICKS, RST_LONG_TICKS, RST_HOLD_TICKS,
                RST_IDLE_LIMIT};
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_held[k]    = 1'b0;
      press_cnt[k]   = '0;
      release_cnt[k] = '0;
      run_down[k]    = 1'b0;
      run_left[k]    = 0;
    end
    quiet_cnt = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed ticks on reset settings
    foreach (DIR_ROWS[r])
      send_tick(DIR_ROWS[r].levels, DIR_ROWS[r].typed, DIR_ROWS[r].n_ev, DIR_ROWS[r].kind);

    // hold repeat lifts the press count to just under the top, whence it climbs to the top and sticks;
    // idle limit at the top; spare indexes written last
    set_thresholds(0, 1, int'(CNT_MAX) - 1, 3, CNT_MAX);
    for (int a = REG_SPARE_FIRST; a <= REG_SPARE_LAST; a++) write_reg(CFG_IDX_W'(a), '0);
    repeat (8) send_tick(3'b001, 1'b0, 0, EV_PRESS);
    repeat (3) send_tick(3'b000, 1'b0, 0, EV_PRESS);

    // small random thresholds in order
    lng = $urandom_range(7, 4);
    set_thresholds($urandom_range(2), $urandom_range(3, 1), lng, lng + $urandom_range(4, 1),
                   $urandom_range(3));
    send_random(20, 0);
    // sender holds off until the block has answered everything
    wait_drained();
    send_random(20, 0);

    // zero press, long and idle thresholds
    set_thresholds(1, 0, 0, 3, 0);
    send_random(20, 0);

    // thresholds out of order
    set_thresholds(1, 5, 2, 3, 2);
    send_random(20, 0);

    // equal press and long thresholds
    set_thresholds(0, 2, 2, 4, 1);
    send_random(15, 0);

    // everything at the top
    set_thresholds(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
    send_random(10, 0);

    // back to small thresholds until plenty of events have come
    lng = $urandom_range(6, 3);
    set_thresholds($urandom_range(1), $urandom_range(2, 1), lng, lng + $urandom_range(3, 1),
                   $urandom_range(2));
    send_random(30, 48);

    wait_drained();
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
